/* rtl/core/nandcs_pkg.sv */
// Shared types, command codes and the bus cycle table of the NAND cycle sequencer.
package nandcs_pkg;

    // Default geometry of the device; both must be powers of two.
    localparam int PageBytesDflt     = 2048;
    localparam int PagesPerBlockDflt = 64;

    // Depths of the request queue and of the result queue.
    localparam int ReqQueueDepth = 2;
    localparam int OutQueueDepth = 2;

    // Widths of the fixed fields.
    localparam int AddrW  = 35;
    localparam int BlockW = 18;
    localparam int ColW   = 16;
    localparam int RowW   = 24;
    localparam int StepW  = 4;

    // Command bytes of the large-page command set.
    localparam logic [7:0] CmdRead1     = 8'h00;
    localparam logic [7:0] CmdRead2     = 8'h30;
    localparam logic [7:0] CmdRndRead1  = 8'h05;
    localparam logic [7:0] CmdRndRead2  = 8'hE0;
    localparam logic [7:0] CmdProg1     = 8'h80;
    localparam logic [7:0] CmdProgCol   = 8'h85;
    localparam logic [7:0] CmdProg2     = 8'h10;
    localparam logic [7:0] CmdStatus    = 8'h70;
    localparam logic [7:0] CmdErase1    = 8'h60;
    localparam logic [7:0] CmdErase2    = 8'hD0;

    typedef enum logic [1:0] {
        RK_READ  = 2'd0,
        RK_PROG  = 2'd1,
        RK_ERASE = 2'd2
    } t_req_kind;

    typedef enum logic [2:0] {
        CK_CMD    = 3'd0,
        CK_ADDR   = 3'd1,
        CK_DWRITE = 3'd2,
        CK_DREAD  = 3'd3,
        CK_WAIT   = 3'd4
    } t_cycle_kind;

    // A classified request as it waits between the front and the back.
    typedef struct packed {
        t_req_kind         kind;
        logic [ColW-1:0]   col;
        logic [RowW-1:0]   row;
        logic [7:0]        data;
    } t_req_desc;

    // One bus cycle as it leaves the block.
    typedef struct packed {
        t_cycle_kind kind;
        logic [7:0]  cbyte;
        logic        last;
    } t_bus_cycle;

    // Handshake between the back end and the two queues around it.
    typedef struct packed {
        logic req_pop;
        logic out_push;
    } t_back_ctrl;

    // Bus cycle number step of a request of the given kind.
    function automatic t_bus_cycle seq_cycle(
        input t_req_kind         kind,
        input logic [StepW-1:0]  step,
        input logic [ColW-1:0]   col,
        input logic [RowW-1:0]   row,
        input logic [7:0]        data
    );
        t_bus_cycle c;
        c = '{CK_WAIT, 8'h00, 1'b1};
        unique case (kind)
            RK_READ: begin
                unique case (step)
                    4'd0:    c = '{CK_CMD,   CmdRead1,    1'b0};
                    4'd1:    c = '{CK_ADDR,  8'h00,       1'b0};
                    4'd2:    c = '{CK_ADDR,  8'h00,       1'b0};
                    4'd3:    c = '{CK_ADDR,  row[7:0],    1'b0};
                    4'd4:    c = '{CK_ADDR,  row[15:8],   1'b0};
                    4'd5:    c = '{CK_ADDR,  row[23:16],  1'b0};
                    4'd6:    c = '{CK_CMD,   CmdRead2,    1'b0};
                    4'd7:    c = '{CK_WAIT,  8'h00,       1'b0};
                    4'd8:    c = '{CK_CMD,   CmdRndRead1, 1'b0};
                    4'd9:    c = '{CK_ADDR,  col[7:0],    1'b0};
                    4'd10:   c = '{CK_ADDR,  col[15:8],   1'b0};
                    4'd11:   c = '{CK_CMD,   CmdRndRead2, 1'b0};
                    default: c = '{CK_DREAD, 8'h00,       1'b1};
                endcase
            end
            RK_PROG: begin
                unique case (step)
                    4'd0:    c = '{CK_CMD,    CmdProg1,   1'b0};
                    4'd1:    c = '{CK_ADDR,   8'h00,      1'b0};
                    4'd2:    c = '{CK_ADDR,   8'h00,      1'b0};
                    4'd3:    c = '{CK_ADDR,   row[7:0],   1'b0};
                    4'd4:    c = '{CK_ADDR,   row[15:8],  1'b0};
                    4'd5:    c = '{CK_ADDR,   row[23:16], 1'b0};
                    4'd6:    c = '{CK_CMD,    CmdProgCol, 1'b0};
                    4'd7:    c = '{CK_ADDR,   col[7:0],   1'b0};
                    4'd8:    c = '{CK_ADDR,   col[15:8],  1'b0};
                    4'd9:    c = '{CK_DWRITE, data,       1'b0};
                    4'd10:   c = '{CK_CMD,    CmdProg2,   1'b0};
                    4'd11:   c = '{CK_WAIT,   8'h00,      1'b0};
                    4'd12:   c = '{CK_CMD,    CmdStatus,  1'b0};
                    default: c = '{CK_WAIT,   8'h00,      1'b1};
                endcase
            end
            RK_ERASE: begin
                unique case (step)
                    4'd0:    c = '{CK_CMD,  CmdErase1,  1'b0};
                    4'd1:    c = '{CK_ADDR, row[7:0],   1'b0};
                    4'd2:    c = '{CK_ADDR, row[15:8],  1'b0};
                    4'd3:    c = '{CK_ADDR, row[23:16], 1'b0};
                    4'd4:    c = '{CK_CMD,  CmdErase2,  1'b0};
                    4'd5:    c = '{CK_WAIT, 8'h00,      1'b0};
                    4'd6:    c = '{CK_CMD,  CmdStatus,  1'b0};
                    default: c = '{CK_WAIT, 8'h00,      1'b1};
                endcase
            end
            default: c = '{CK_WAIT, 8'h00, 1'b1};
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/nand_cycle_sequencer.sv */
// Top level of the NAND cycle sequencer: front end, request queue, back end, result queue.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+----------------------------------------
//  request   | in        | push / full          | i_req_type, i_byte_address,
//            |           |                      | i_write_data, i_block_number
//  bus cycle | out       | empty / pop          | o_cycle_kind, o_cycle_byte, o_last_cycle
//
//  A request becomes 13 (read), 14 (program) or 8 (erase) bus cycles; a request type
//  of three is dropped and produces no transfer. The back end issues one bus cycle per
//  clock while a request waits and the result queue has room, with no gap between requests.
//  Reset is synchronous and active low and empties both queues; there is no clearing pass.
//  A full result queue stalls only the back end; the front end keeps taking requests
//  until the request queue and its own register are full.
module nand_cycle_sequencer #(
    parameter int PAGE_BYTES      = nandcs_pkg::PageBytesDflt,
    parameter int PAGES_PER_BLOCK = nandcs_pkg::PagesPerBlockDflt
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_req_type,
    input  logic [nandcs_pkg::AddrW-1:0]  i_byte_address,
    input  logic [7:0]                    i_write_data,
    input  logic [nandcs_pkg::BlockW-1:0] i_block_number,
    output logic                          empty,
    input  logic                          pop,
    output logic [2:0]                    o_cycle_kind,
    output logic [7:0]                    o_cycle_byte,
    output logic                          o_last_cycle
);
    import nandcs_pkg::*;

    localparam int DescW  = $bits(t_req_desc);
    localparam int CycleW = $bits(t_bus_cycle);

    // Classified request from the front end into the request queue.
    logic        front_valid;
    t_req_desc   front_desc;
    logic        req_full;

    // Head of the request queue as the back end sees it.
    logic        req_empty;
    logic [DescW-1:0] req_head_bits;
    t_req_desc   req_head;

    // Back end handshake and the bus cycle it produces.
    t_back_ctrl  back_ctrl;
    t_bus_cycle  back_cycle;
    logic        out_full;
    logic [CycleW-1:0] out_head_bits;
    t_bus_cycle  out_head;

    nandcs_front #(
        .PAGE_BYTES      (PAGE_BYTES),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_byte_address (i_byte_address),
        .i_write_data   (i_write_data),
        .i_block_number (i_block_number),
        .o_desc_valid   (front_valid),
        .o_desc         (front_desc),
        .i_queue_full   (req_full)
    );

    // Request queue: lets the front end take new requests while the back end
    // is still busy with a long sequence.
    nandcs_fifo #(
        .W     (DescW),
        .DEPTH (ReqQueueDepth)
    ) u_req_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_full  (req_full),
        .i_data  (front_desc),
        .o_empty (req_empty),
        .i_pop   (back_ctrl.req_pop),
        .o_data  (req_head_bits)
    );

    assign req_head = t_req_desc'(req_head_bits);

    nandcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (!req_empty),
        .i_req       (req_head),
        .i_out_full  (out_full),
        .o_ctrl      (back_ctrl),
        .o_cycle     (back_cycle)
    );

    // Result queue: a registered output stage, so a result waiting for pop
    // blocks the back end from producing the next one only once the queue is full.
    nandcs_fifo #(
        .W     (CycleW),
        .DEPTH (OutQueueDepth)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_ctrl.out_push),
        .o_full  (out_full),
        .i_data  (back_cycle),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (out_head_bits)
    );

    assign out_head     = t_bus_cycle'(out_head_bits);
    assign o_cycle_kind = out_head.kind;
    assign o_cycle_byte = out_head.cbyte;
    assign o_last_cycle = out_head.last;

`ifndef NO_ASSERTIONS
    // The back end never idles while it has a request and room for the result.
    a_back_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!req_empty && !out_full) |-> back_ctrl.out_push)
        else $error("back end idles with work pending");

    // A request only leaves the queue on the cycle that closes its sequence.
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_ctrl.req_pop |-> (back_ctrl.out_push && back_cycle.last))
        else $error("request dropped before its final bus cycle");

    // A data read transfer always closes a read sequence and carries no byte.
    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cycle_kind == CK_DREAD) |-> (o_last_cycle && o_cycle_byte == 8'h00))
        else $error("data read cycle is not the final cycle");

    // Wait cycles never drive a byte onto the bus.
    a_wait_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cycle_kind == CK_WAIT) |-> (o_cycle_byte == 8'h00))
        else $error("wait cycle carries a byte");
`endif

endmodule

/* rtl/core/nandcs_fifo.sv */
// Small register queue used for the request queue and the result queue.
module nandcs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [W-1:0] i_data,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            w_wr, w_rd;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/nandcs_front.sv */
// Front end: takes requests, splits the address and queues a classified request.
module nandcs_front #(
    parameter int PAGE_BYTES      = nandcs_pkg::PageBytesDflt,
    parameter int PAGES_PER_BLOCK = nandcs_pkg::PagesPerBlockDflt
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_req_type,
    input  logic [nandcs_pkg::AddrW-1:0]  i_byte_address,
    input  logic [7:0]                    i_write_data,
    input  logic [nandcs_pkg::BlockW-1:0] i_block_number,
    output logic                          o_desc_valid,
    output nandcs_pkg::t_req_desc         o_desc,
    input  logic                          i_queue_full
);
    import nandcs_pkg::*;

    localparam int ColBits = $clog2(PAGE_BYTES);
    localparam int PbW     = $clog2(PAGES_PER_BLOCK + 1);
    localparam int ProdW   = BlockW + PbW;

    logic            r_valid, n_valid;
    t_req_desc       r_desc, n_desc;
    logic            w_take, w_known;
    logic [ProdW-1:0] w_erow;

    assign full   = r_valid && i_queue_full;
    assign w_take = push && !full;
    assign w_erow = ProdW'(i_block_number) * ProdW'(PAGES_PER_BLOCK);

    always_comb begin
        n_desc      = r_desc;
        w_known     = 1'b1;
        n_desc.col  = ColW'(i_byte_address[ColBits-1:0]);
        n_desc.row  = RowW'(i_byte_address >> ColBits);
        n_desc.data = i_write_data;
        n_desc.kind = RK_READ;
        unique case (i_req_type)
            RK_READ: n_desc.kind = RK_READ;
            RK_PROG: n_desc.kind = RK_PROG;
            RK_ERASE: begin
                n_desc.kind = RK_ERASE;
                n_desc.row  = RowW'(w_erow);
            end
            default: w_known = 1'b0;
        endcase
    end

    // The held request leaves as soon as the queue has room; a new one may
    // enter in the same cycle.
    always_comb begin
        n_valid = r_valid && i_queue_full;
        if (w_take && w_known) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_known) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

endmodule

/* rtl/core/nandcs_back.sv */
// Back end: walks the bus cycles of the request at the head of the queue.
module nandcs_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  nandcs_pkg::t_req_desc  i_req,
    input  logic                   i_out_full,
    output nandcs_pkg::t_back_ctrl o_ctrl,
    output nandcs_pkg::t_bus_cycle o_cycle
);
    import nandcs_pkg::*;

    logic [StepW-1:0] r_step, n_step;
    t_bus_cycle       w_cyc;
    logic             w_emit;

    assign w_cyc  = seq_cycle(i_req.kind, r_step, i_req.col, i_req.row, i_req.data);
    assign w_emit = i_req_valid && !i_out_full;

    always_comb begin
        n_step = r_step;
        if (w_emit) begin
            n_step = w_cyc.last ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.out_push = w_emit;
    assign o_ctrl.req_pop  = w_emit && w_cyc.last;
    assign o_cycle         = w_cyc;

endmodule

/* tb/nand_cycle_sequencer_tb.sv */
// Self-checking testbench of the NAND cycle sequencer, with its own bus cycle predictor.
`timescale 1ns / 1ps

module nand_cycle_sequencer_tb;
    import nandcs_pkg::*;

    // The device geometry that both the block and the predictor assume.
    localparam int PageBytes     = 2048;
    localparam int PagesPerBlock = 64;
    localparam int ColBits       = $clog2(PageBytes);

    // A request type of three selects nothing and must be dropped by the block.
    localparam logic [1:0] ReqUnused = 2'd3;

    // The watchdog fires after this many cycles in which no transfer happens.
    localparam int StallLimit     = 2000;
    // Cycles allowed after the last result for a stray result to show up.
    localparam int EndDrainCycles = 32;

    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              push           = 1'b0;
    logic              full;
    logic [1:0]        i_req_type     = '0;
    logic [AddrW-1:0]  i_byte_address = '0;
    logic [7:0]        i_write_data   = '0;
    logic [BlockW-1:0] i_block_number = '0;
    logic              empty;
    logic              pop            = 1'b0;
    logic [2:0]        o_cycle_kind;
    logic [7:0]        o_cycle_byte;
    logic              o_last_cycle;

    // Bus cycles predicted for the requests accepted so far, oldest first.
    t_bus_cycle pending_cycles[$];
    t_bus_cycle oldest_cycle;

    int mismatch_count = 0;
    int stall_cycles   = 0;
    // Chances out of a hundred that the request side or the result side idles in a cycle.
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    nand_cycle_sequencer #(
        .PAGE_BYTES      (PageBytes),
        .PAGES_PER_BLOCK (PagesPerBlock)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_byte_address (i_byte_address),
        .i_write_data   (i_write_data),
        .i_block_number (i_block_number),
        .empty          (empty),
        .pop            (pop),
        .o_cycle_kind   (o_cycle_kind),
        .o_cycle_byte   (o_cycle_byte),
        .o_last_cycle   (o_last_cycle)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Prints one line for each mismatch and keeps the count that decides the verdict.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic void queue_cycle(input t_cycle_kind kind, input logic [7:0] cbyte,
                                        input logic last);
        t_bus_cycle c;
        c.kind  = kind;
        c.cbyte = cbyte;
        c.last  = last;
        pending_cycles.push_back(c);
    endfunction

    // Appends the bus cycles that one accepted request must turn into. The
    // column is the byte offset inside the page and the row is the page
    // number, cut to the three address bytes that the device takes. An
    // erase addresses the first page of its block. Fields that a request
    // does not use play no part, and an unused request type adds nothing.
    function automatic void predict_bus_cycles(input logic [1:0] req_type,
                                               input logic [AddrW-1:0] byte_address,
                                               input logic [7:0] write_data,
                                               input logic [BlockW-1:0] block_number);
        logic [15:0]     col;
        logic [RowW-1:0] row;
        logic [RowW-1:0] erase_row;
        col       = 16'(byte_address % PageBytes);
        row       = RowW'(byte_address >> ColBits);
        erase_row = RowW'(64'(block_number) * PagesPerBlock);
        case (req_type)
            RK_READ: begin
                queue_cycle(CK_CMD,   CmdRead1,     1'b0);
                queue_cycle(CK_ADDR,  8'h00,        1'b0);
                queue_cycle(CK_ADDR,  8'h00,        1'b0);
                queue_cycle(CK_ADDR,  row[7:0],     1'b0);
                queue_cycle(CK_ADDR,  row[15:8],    1'b0);
                queue_cycle(CK_ADDR,  row[23:16],   1'b0);
                queue_cycle(CK_CMD,   CmdRead2,     1'b0);
                queue_cycle(CK_WAIT,  8'h00,        1'b0);
                queue_cycle(CK_CMD,   CmdRndRead1,  1'b0);
                queue_cycle(CK_ADDR,  col[7:0],     1'b0);
                queue_cycle(CK_ADDR,  col[15:8],    1'b0);
                queue_cycle(CK_CMD,   CmdRndRead2,  1'b0);
                // The byte of a read cycle comes from the device, so the block drives zero.
                queue_cycle(CK_DREAD, 8'h00,        1'b1);
            end
            RK_PROG: begin
                queue_cycle(CK_CMD,    CmdProg1,    1'b0);
                queue_cycle(CK_ADDR,   8'h00,       1'b0);
                queue_cycle(CK_ADDR,   8'h00,       1'b0);
                queue_cycle(CK_ADDR,   row[7:0],    1'b0);
                queue_cycle(CK_ADDR,   row[15:8],   1'b0);
                queue_cycle(CK_ADDR,   row[23:16],  1'b0);
                queue_cycle(CK_CMD,    CmdProgCol,  1'b0);
                queue_cycle(CK_ADDR,   col[7:0],    1'b0);
                queue_cycle(CK_ADDR,   col[15:8],   1'b0);
                queue_cycle(CK_DWRITE, write_data,  1'b0);
                queue_cycle(CK_CMD,    CmdProg2,    1'b0);
                queue_cycle(CK_WAIT,   8'h00,       1'b0);
                queue_cycle(CK_CMD,    CmdStatus,   1'b0);
                queue_cycle(CK_WAIT,   8'h00,       1'b1);
            end
            RK_ERASE: begin
                queue_cycle(CK_CMD,  CmdErase1,         1'b0);
                queue_cycle(CK_ADDR, erase_row[7:0],    1'b0);
                queue_cycle(CK_ADDR, erase_row[15:8],   1'b0);
                queue_cycle(CK_ADDR, erase_row[23:16],  1'b0);
                queue_cycle(CK_CMD,  CmdErase2,         1'b0);
                queue_cycle(CK_WAIT, 8'h00,             1'b0);
                queue_cycle(CK_CMD,  CmdStatus,         1'b0);
                queue_cycle(CK_WAIT, 8'h00,             1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    // Offers one request and returns once its transfer has happened. Push is
    // left high so that back-to-back requests need no gap; the next call
    // either keeps it high or lowers it for an idle cycle, never both in one
    // time step.
    task automatic send_request(input logic [1:0] req_type, input logic [AddrW-1:0] byte_address,
                                input logic [7:0] write_data,
                                input logic [BlockW-1:0] block_number);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_req_type     <= req_type;
        i_byte_address <= byte_address;
        i_write_data   <= write_data;
        i_block_number <= block_number;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_bus_cycles(req_type, byte_address, write_data, block_number);
    endtask

    // Holds the request side quiet until every predicted bus cycle has been taken.
    task automatic wait_until_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_cycles.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of the address split, every request type, the dropped type,
    // and junk in the fields that a request ignores.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_request(RK_READ,   '0,            8'h00, '0);
        send_request(RK_READ,   '1,            8'h00, '0);
        send_request(RK_READ,   35'h700,       8'hFF, '1);
        send_request(RK_READ,   35'h4_0000_0000, 8'h5A, 18'h2AAAA);
        send_request(RK_READ,   35'h2_AAAA_A555, 8'h00, '0);
        send_request(RK_PROG,   '0,            8'h00, '0);
        send_request(RK_PROG,   '1,            8'hFF, '1);
        send_request(RK_PROG,   35'h5_5555_52AA, 8'hA5, 18'h15555);
        send_request(RK_PROG,   35'h7FF,       8'h01, '0);
        send_request(RK_ERASE,  '0,            8'h00, '0);
        send_request(RK_ERASE,  '1,            8'hFF, '1);
        send_request(RK_ERASE,  '0,            8'h00, 18'h2AAAA);
        send_request(RK_ERASE,  '1,            8'hFF, 18'h1);
        send_request(ReqUnused, '1,            8'hFF, '1);
        send_request(ReqUnused, '0,            8'h00, '0);
        send_request(RK_READ,   35'h0_0000_0801, 8'h00, '0);
        wait_until_drained();
    endtask

    // Random content in the same request stream, with a full drain in the
    // middle and a request that arrives at a block that has gone idle.
    task automatic test_pause_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 30;
        send_request(RK_PROG,  {$urandom, $urandom}, 8'($urandom), 18'($urandom));
        send_request(RK_READ,  {$urandom, $urandom}, 8'($urandom), 18'($urandom));
        send_request(RK_ERASE, {$urandom, $urandom}, 8'($urandom), 18'($urandom));
        wait_until_drained();
        send_request(RK_READ,  {$urandom, $urandom}, 8'($urandom), 18'($urandom));
        send_request(ReqUnused, {$urandom, $urandom}, 8'($urandom), 18'($urandom));
        send_request(RK_PROG,  {$urandom, $urandom}, 8'($urandom), 18'($urandom));
        wait_until_drained();
    endtask

    // Mostly valid requests with random content; a few of the dropped type
    // are mixed in as noise. Addresses and block numbers are sometimes
    // pushed to the ends of their ranges so that the row bytes see
    // all-zero and all-one patterns as well as random ones.
    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        logic [1:0]        req_type;
        logic [AddrW-1:0]  byte_address;
        logic [BlockW-1:0] block_number;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            if ($urandom_range(0, 99) < 8) begin
                req_type = ReqUnused;
            end else begin
                req_type = 2'($urandom_range(0, 2));
            end
            byte_address = AddrW'({$urandom, $urandom});
            case ($urandom_range(0, 3))
                0: byte_address = AddrW'($urandom_range(0, 4 * PageBytes - 1));
                1: byte_address = byte_address | ~AddrW'(PageBytes - 1);
                default: begin
                end
            endcase
            block_number = BlockW'($urandom);
            case ($urandom_range(0, 3))
                0: block_number = BlockW'($urandom_range(0, 7));
                1: block_number = block_number | 18'h3FF00;
                default: begin
                end
            endcase
            send_request(req_type, byte_address, 8'($urandom), block_number);
        end
        wait_until_drained();
    endtask

    // The result side asks for a transfer unless a random draw against the set idle chance makes it idle.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every result transfer is held against the oldest predicted bus cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_cycles.size() == 0) begin
                report_mismatch("bus cycle with no request behind it", o_cycle_byte, 8'h00);
            end else begin
                oldest_cycle = pending_cycles.pop_front();
                if (o_cycle_kind != oldest_cycle.kind) begin
                    report_mismatch("cycle kind", 8'(o_cycle_kind), 8'(oldest_cycle.kind));
                end
                if (o_cycle_byte != oldest_cycle.cbyte) begin
                    report_mismatch("cycle byte", o_cycle_byte, oldest_cycle.cbyte);
                end
                if (o_last_cycle != oldest_cycle.last) begin
                    report_mismatch("last cycle flag", 8'(o_last_cycle), 8'(oldest_cycle.last));
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer means the block is stuck.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("TIMEOUT after %0d cycles without a transfer", stall_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pause_until_drained();
        test_random(88, 17, 51);
        test_random(88, 51, 17);
        test_random(88, 0, 0);

        // Give a stray extra bus cycle time to appear before the verdict.
        repeat (EndDrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
